FILE: rtl/core/kwm_pkg.sv
// Shared types, sizes and codes of the k-way run merge block.
package kwm_pkg;

   localparam int NUM_RUNS      = 8;
   localparam int RUN_DEPTH     = 16;
   localparam int KEY_WIDTH     = 32;
   localparam int PAYLOAD_WIDTH = 32;

   localparam int RUN_W   = $clog2(NUM_RUNS);
   localparam int RCNT_W  = $clog2(NUM_RUNS + 1);
   localparam int PTR_W   = $clog2(RUN_DEPTH);
   localparam int CNT_W   = $clog2(RUN_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_RUNS * RUN_DEPTH;
   localparam int ADDR_W  = $clog2(MEM_DEPTH);
   localparam int REC_W   = KEY_WIDTH + PAYLOAD_WIDTH;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_RUNS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNED_KEYS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DESCENDING  = 2'd2;

   localparam logic [3:0] RUNS_IN_USE_RESET = 4'd8;

   localparam logic [1:0] ACT_APPEND  = 2'd0;
   localparam logic [1:0] ACT_END     = 2'd1;
   localparam logic [1:0] ACT_POP     = 2'd2;
   localparam logic [1:0] ACT_RESTART = 2'd3;

   localparam logic [2:0] STAT_ACCEPTED = 3'd0;
   localparam logic [2:0] STAT_RECORD   = 3'd1;
   localparam logic [2:0] STAT_REFILL   = 3'd2;
   localparam logic [2:0] STAT_FINISHED = 3'd3;
   localparam logic [2:0] STAT_REJECTED = 3'd4;

   typedef struct packed {
      logic [1:0]  action;
      logic [2:0]  run_index;
      logic [31:0] record_key;
      logic [31:0] record_payload;
   } kwm_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_key;
      logic [31:0] out_payload;
      logic [2:0]  out_run;
      logic        out_last;
   } kwm_rsp_type;

   typedef struct packed {
      logic capture;
      logic scan_start;
      logic scan_step;
      logic finish;
   } kwm_cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_last;
   } kwm_stat_type;

endpackage

FILE: rtl/core/kwm_ctrl.sv
// Controller state machine of the k-way run merge block.
module kwm_ctrl
   import kwm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  kwm_stat_type stat,
   output kwm_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.capture    = (state_ff == ST_IDLE) && req_valid;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.scan_start = 1'b1;
            state_in = stat.need_scan ? ST_SCAN : ST_FINISH;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // drop the result once taken, set it when a new one lands
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/core/kwm_dpath.sv
// Datapath of the k-way run merge block: run FIFOs, record memory, head scan.
module kwm_dpath
   import kwm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  kwm_req_type          req_data,
   input  kwm_cmd_type          cmd,
   output kwm_stat_type         stat,
   output kwm_rsp_type          rsp_data
);

   function automatic logic [ADDR_W-1:0] rec_addr(input logic [RUN_W-1:0] run,
                                                  input logic [PTR_W-1:0] ptr);
      rec_addr = ADDR_W'(int'(run) * RUN_DEPTH + int'(ptr));
   endfunction

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      next_ptr = (int'(ptr) == RUN_DEPTH - 1) ? '0 : ptr + PTR_W'(1);
   endfunction

   function automatic logic goes_before(input logic [KEY_WIDTH-1:0] a,
                                        input logic [KEY_WIDTH-1:0] b,
                                        input logic sgn,
                                        input logic desc);
      logic [KEY_WIDTH-1:0] ax;
      logic [KEY_WIDTH-1:0] bx;
      ax = a;
      bx = b;
      ax[KEY_WIDTH-1] = a[KEY_WIDTH-1] ^ sgn;
      bx[KEY_WIDTH-1] = b[KEY_WIDTH-1] ^ sgn;
      goes_before = desc ? (ax > bx) : (ax < bx);
   endfunction

   // configuration
   logic [CSR_W-1:0]  runs_ff;
   logic              signed_ff;
   logic              desc_ff;
   logic [RCNT_W-1:0] n_act;

   // run bookkeeping
   logic [PTR_W-1:0] head_ff [NUM_RUNS];
   logic [PTR_W-1:0] tail_ff [NUM_RUNS];
   logic [CNT_W-1:0] fill_ff [NUM_RUNS];
   logic [NUM_RUNS-1:0] fin_ff;

   // record memory
   logic [REC_W-1:0]  mem [MEM_DEPTH];
   logic [REC_W-1:0]  mem_q_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              mem_we;

   // item and scan state
   kwm_req_type          item_ff;
   logic [RUN_W-1:0]     scan_idx_ff;
   logic                 rd_valid_ff, rd_valid_in;
   logic [RUN_W-1:0]     rd_run_ff;
   logic                 found_ff;
   logic [RUN_W-1:0]     best_run_ff;
   logic [KEY_WIDTH-1:0] best_key_ff;
   logic [PAYLOAD_WIDTH-1:0] best_pay_ff;
   logic [KEY_WIDTH-1:0] q_key;
   logic                 take_q;
   kwm_rsp_type          rsp_ff, rsp_in;

   // decode of the held item
   logic [RUN_W-1:0] run_sel;
   logic             run_ok;
   logic             append_ok;
   logic             refill_any;
   logic [RUN_W-1:0] refill_run;
   logic             any_nonempty;
   logic             last_after;

   always_comb begin
      if (runs_ff == '0)
         n_act = RCNT_W'(1);
      else if (int'(runs_ff) > NUM_RUNS)
         n_act = RCNT_W'(NUM_RUNS);
      else
         n_act = RCNT_W'(runs_ff);
   end

   assign run_sel   = RUN_W'(item_ff.run_index);
   assign run_ok    = int'(item_ff.run_index) < int'(n_act);
   assign append_ok = run_ok && !fin_ff[run_sel] && (int'(fill_ff[run_sel]) < RUN_DEPTH);

   // lowest live empty run, any non-empty run, and done-after-pop check
   always_comb begin
      refill_any   = 1'b0;
      refill_run   = '0;
      any_nonempty = 1'b0;
      last_after   = 1'b1;
      for (int r = NUM_RUNS - 1; r >= 0; r--) begin
         if (r < int'(n_act)) begin
            if (fill_ff[r] == '0 && !fin_ff[r]) begin
               refill_any = 1'b1;
               refill_run = RUN_W'(r);
            end
            if (fill_ff[r] != '0) any_nonempty = 1'b1;
            if (!fin_ff[r]) last_after = 1'b0;
            if (!(fill_ff[r] == '0 ||
                  (int'(best_run_ff) == r && fill_ff[r] == CNT_W'(1))))
               last_after = 1'b0;
         end
      end
   end

   assign stat.need_scan = (item_ff.action == ACT_POP) && !refill_any && any_nonempty;
   assign stat.scan_last = int'(scan_idx_ff) == int'(n_act) - 1;

   // scan reads one run head per cycle; the compare uses the registered read in the cycle after
   assign rd_addr     = rec_addr(scan_idx_ff, head_ff[scan_idx_ff]);
   assign rd_valid_in = cmd.scan_step && (fill_ff[scan_idx_ff] != '0);
   assign q_key       = mem_q_ff[REC_W-1:PAYLOAD_WIDTH];
   assign take_q      = rd_valid_ff &&
                        (!found_ff || goes_before(q_key, best_key_ff, signed_ff, desc_ff));

   assign mem_we  = cmd.finish && (item_ff.action == ACT_APPEND) && append_ok;
   assign wr_addr = rec_addr(run_sel, tail_ff[run_sel]);

   always_comb begin
      rsp_in        = '0;
      rsp_in.status = STAT_ACCEPTED;
      case (item_ff.action)
         ACT_APPEND: begin
            if (!append_ok) rsp_in.status = STAT_REJECTED;
         end
         ACT_POP: begin
            if (refill_any) begin
               rsp_in.status  = STAT_REFILL;
               rsp_in.out_run = 3'(refill_run);
            end else if (!any_nonempty) begin
               rsp_in.status = STAT_FINISHED;
            end else begin
               rsp_in.status      = STAT_RECORD;
               rsp_in.out_key     = 32'(best_key_ff);
               rsp_in.out_payload = 32'(best_pay_ff);
               rsp_in.out_run     = 3'(best_run_ff);
               rsp_in.out_last    = last_after;
            end
         end
         default: begin
            rsp_in.status = STAT_ACCEPTED;
         end
      endcase
   end

   assign rsp_data = rsp_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         runs_ff     <= RUNS_IN_USE_RESET;
         signed_ff   <= 1'b0;
         desc_ff     <= 1'b0;
         fin_ff      <= '0;
         scan_idx_ff <= '0;
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
         for (int r = 0; r < NUM_RUNS; r++) begin
            head_ff[r] <= '0;
            tail_ff[r] <= '0;
            fill_ff[r] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RUNS_IN_USE: runs_ff   <= csr_wdata;
               CSR_SIGNED_KEYS: signed_ff <= csr_wdata[0];
               CSR_DESCENDING:  desc_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
         rd_valid_ff <= rd_valid_in;
         if (cmd.scan_start) begin
            scan_idx_ff <= '0;
            found_ff    <= 1'b0;
         end else begin
            if (cmd.scan_step) scan_idx_ff <= scan_idx_ff + RUN_W'(1);
            if (take_q) found_ff <= 1'b1;
         end
         if (cmd.finish) begin
            case (item_ff.action)
               ACT_APPEND: begin
                  if (append_ok) begin
                     tail_ff[run_sel] <= next_ptr(tail_ff[run_sel]);
                     fill_ff[run_sel] <= fill_ff[run_sel] + CNT_W'(1);
                  end
               end
               ACT_END: begin
                  if (run_ok) fin_ff[run_sel] <= 1'b1;
               end
               ACT_POP: begin
                  if (!refill_any && any_nonempty) begin
                     head_ff[best_run_ff] <= next_ptr(head_ff[best_run_ff]);
                     fill_ff[best_run_ff] <= fill_ff[best_run_ff] - CNT_W'(1);
                  end
               end
               ACT_RESTART: begin
                  fin_ff <= '0;
                  for (int r = 0; r < NUM_RUNS; r++) begin
                     head_ff[r] <= '0;
                     tail_ff[r] <= '0;
                     fill_ff[r] <= '0;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // payload registers and record memory
   always_ff @(posedge clock) begin
      if (mem_we)
         mem[wr_addr] <= {KEY_WIDTH'(item_ff.record_key),
                          PAYLOAD_WIDTH'(item_ff.record_payload)};
      mem_q_ff  <= mem[rd_addr];
      rd_run_ff <= scan_idx_ff;
      if (cmd.capture) item_ff <= req_data;
      if (take_q && !cmd.scan_start) begin
         best_run_ff <= rd_run_ff;
         best_key_ff <= q_key;
         best_pay_ff <= mem_q_ff[PAYLOAD_WIDTH-1:0];
      end
      if (cmd.finish) rsp_ff <= rsp_in;
   end

endmodule

FILE: rtl/core/kway_run_merge.sv
// Top level of the k-way run merge block: controller plus datapath.
// Append, end, restart and non-choosing pops pass from idle through exec to finish, which registers
// the result; a pop that chooses a record passes through scan and drain before finish. The head scan
// reads one run head per cycle from the single read port of the record memory.
// A new item is taken only in idle, so items never overlap; finish waits while a result is untaken.
// Reset clears pointers, fill counts, finished marks and control state, not the record store.
module kway_run_merge
   import kwm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  kwm_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output kwm_rsp_type          rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // commands from the controller, status back from the datapath
   kwm_cmd_type  cmd;
   kwm_stat_type stat;

   // sequence items: capture, decide, scan heads, then retire into the output register
   kwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold run FIFOs, record memory, best-head compare and the result register
   kwm_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

   // a result must never land on top of one that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten");

   // after a transfer in, hold off the next item
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while busy");

   // only a given record carries key, payload or a last flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STAT_RECORD) |->
         (rsp_data.out_key == '0 && rsp_data.out_payload == '0 && !rsp_data.out_last))
      else $error("non-record result carries data");

   // a new result appears only as the controller retires an item
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.finish))
      else $error("result without retire");

endmodule
